// File: design/ctbg_pkg.sv
// ----------------------------------------------------------------------------
// ctbg_pkg: shared definitions for the complementary tone burst generator
// Constants, request codes and sequencer states used by the divider and top.
// ----------------------------------------------------------------------------
package ctbg_pkg;

    // period counter width
    localparam int COUNT_WIDTH = 16;

    // shared divider geometry: 48-bit dividend, 16-bit divisor, one bit a step
    localparam int DIVIDEND_W = 48;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // tone limits and scaling constants
    localparam logic [DIVISOR_W-1:0]  FREQ_MIN      = 16'd20;
    localparam logic [DIVISOR_W-1:0]  FREQ_MAX      = 16'd40000;
    localparam logic [31:0]           CLOCK_DEFAULT = 32'd1000000;
    localparam logic [DIVIDEND_W-1:0] ROUND_HALF    = 48'd500;
    localparam logic [DIVISOR_W-1:0]  MS_PER_S      = 16'd1000;

    // request codes carried in tuser
    typedef logic [1:0] t_req;
    localparam t_req REQ_TICK  = 2'd0;
    localparam t_req REQ_START = 2'd1;
    localparam t_req REQ_STOP  = 2'd2;

    // start sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIVT = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIVP = 4'b1000
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

endpackage

// File: design/ctbg_div.sv
// ----------------------------------------------------------------------------
// ctbg_div: shared restoring divider
// Unsigned 48 by 16 bit division, one quotient bit per cycle, done pulse.
// ----------------------------------------------------------------------------
module ctbg_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ctbg_pkg::t_div_req                i_req,
    output logic                              o_done,
    output logic [ctbg_pkg::DIVIDEND_W-1:0]   o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [ctbg_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [ctbg_pkg::DIVIDEND_W-1:0]  r_quo;
    logic [ctbg_pkg::DIVISOR_W-1:0]   r_rem;
    logic [ctbg_pkg::DIVISOR_W-1:0]   r_dvs;

    logic [ctbg_pkg::DIVISOR_W:0]     shifted;
    logic [ctbg_pkg::DIVISOR_W:0]     diff;
    logic                             fits;
    logic                             last_step;

    // one trial subtraction per cycle
    assign shifted   = {r_rem, r_quo[ctbg_pkg::DIVIDEND_W-1]};
    assign fits      = (shifted >= {1'b0, r_dvs});
    assign diff      = shifted - {1'b0, r_dvs};
    assign last_step = (r_cnt == ctbg_pkg::DIV_CNT_W'(ctbg_pkg::DIV_STEPS - 1));

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ctbg_pkg::DIVIDEND_W-2:0], fits};
            r_rem <= fits ? diff[ctbg_pkg::DIVISOR_W-1:0] : shifted[ctbg_pkg::DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // done comes only out of a running division
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    // remainder stays below the divisor while running
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !$past(i_req.start) && $past(r_busy)) |-> (r_rem < r_dvs))
        else $error("divider remainder out of range");

    // busy and done never overlap
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done together");

endmodule

// File: design/complementary_tone_burst_generator_unit.sv
// ----------------------------------------------------------------------------
// complementary_tone_burst_generator_unit: piezo tone burst generator
// Drives two complementary square waves for the periods of a requested burst_ms.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = request (0 tick, 1 start, 2 stop); tdata carries
//   freq_hz and burst_ms. Every accepted word gives one result word on
//   the master stream: drive_a, drive_b, busy_res, accepted.
//   Config channel: i_cfg_valid/o_cfg_ready/i_cfg_data writes clock_hz
//   (0 means 1 MHz); write only while no request is in flight.
//   Tick, stop and refused starts: the result word is in the
//   output register the cycle after acceptance, and the next word can be
//   taken at once. An accepted start runs two 48-step passes of the
//   shared divider (clock_hz / freq, then (burst_ms * freq + 500) / 1000);
//   state S_MUL launches the second pass after the first is done, and the
//   result word is loaded when the second pass is done.
//   o_s_tready is low while the start is in progress.
//   When the receiver stalls, the result word holds and o_s_tready stays low
//   until it is taken.
//   Reset sets clock_hz to 1 MHz, stops any burst and empties the output.
// ----------------------------------------------------------------------------
module complementary_tone_burst_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,     // clock_hz
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,      // [15:0] freq_hz, [47:16] burst_ms
    input  logic [1:0]  i_s_tuser,      // [1:0] req_type
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata       // [0] drive_a, [1] drive_b, [2] busy_res,
                                        // [3] accepted, [7:4] zero
);

    localparam int CW = ctbg_pkg::COUNT_WIDTH;

    // configuration and burst state
    logic [31:0]        r_clock_hz;
    ctbg_pkg::t_state   r_state, n_state;
    logic [CW-1:0]      r_phase, n_phase;
    logic [CW-1:0]      r_top, n_top;
    logic [CW-1:0]      r_half, n_half;
    logic [31:0]        r_rem, n_rem;
    logic               r_active, n_active;
    logic               n_acc;
    logic               load_out;

    // start working registers
    logic [ctbg_pkg::DIVISOR_W-1:0]  r_freq;
    logic [31:0]                     r_dur;
    logic [CW-1:0]                   r_ticks;
    logic [ctbg_pkg::DIVIDEND_W-1:0] r_prod;

    // output register
    logic               r_out_valid;
    logic [3:0]         r_out_data;

    logic                            in_acc;
    ctbg_pkg::t_req                  req;
    logic [ctbg_pkg::DIVISOR_W-1:0]  freq_in;
    logic [ctbg_pkg::DIVISOR_W-1:0]  freq_cl;
    logic [31:0]                     dur_in;
    logic [31:0]                     clk_eff;
    ctbg_pkg::t_div_req              div_req;
    logic                            div_start;
    logic                            div_done;
    logic [ctbg_pkg::DIVIDEND_W-1:0] div_q;
    logic [CW-1:0]                   ticks_c;
    logic [31:0]                     periods_c;
    logic [31:0]                     rem_dec;
    logic                            drive_a;

    assign req     = i_s_tuser;
    assign freq_in = i_s_tdata[15:0];
    assign dur_in  = i_s_tdata[47:16];
    assign clk_eff = (r_clock_hz == '0) ? ctbg_pkg::CLOCK_DEFAULT : r_clock_hz;

    // clamp requested frequency
    always_comb begin
        if (freq_in < ctbg_pkg::FREQ_MIN) begin
            freq_cl = ctbg_pkg::FREQ_MIN;
        end else if (freq_in > ctbg_pkg::FREQ_MAX) begin
            freq_cl = ctbg_pkg::FREQ_MAX;
        end else begin
            freq_cl = freq_in;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ctbg_pkg::S_IDLE) && (!r_out_valid || i_m_tready);
    assign in_acc      = i_s_tvalid && o_s_tready;

    // shared divider: clock / freq first, then rounded product / 1000
    assign div_req = {div_start,
                      (r_state == ctbg_pkg::S_IDLE) ? {16'b0, clk_eff} : r_prod,
                      (r_state == ctbg_pkg::S_IDLE) ? freq_cl : ctbg_pkg::MS_PER_S};

    ctbg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // period length clamp: 2 .. 2^CW-1
    always_comb begin
        if (div_q[ctbg_pkg::DIVIDEND_W-1:CW] != '0) begin
            ticks_c = '1;
        end else if (div_q[CW-1:0] < CW'(2)) begin
            ticks_c = CW'(2);
        end else begin
            ticks_c = div_q[CW-1:0];
        end
    end

    // period count: at least one, saturated to 32 bits
    always_comb begin
        if (div_q[ctbg_pkg::DIVIDEND_W-1:32] != '0) begin
            periods_c = '1;
        end else if (div_q[31:0] == '0) begin
            periods_c = 32'd1;
        end else begin
            periods_c = div_q[31:0];
        end
    end

    // request handling and start sequencer
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_top     = r_top;
        n_half    = r_half;
        n_rem     = r_rem;
        n_active  = r_active;
        n_acc     = 1'b0;
        load_out  = 1'b0;
        div_start = 1'b0;
        rem_dec   = (r_rem != '0) ? (r_rem - 32'd1) : r_rem;
        case (r_state)
            ctbg_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (req)
                        ctbg_pkg::REQ_TICK: begin
                            load_out = 1'b1;
                            if (r_active) begin
                                if (r_phase >= r_top) begin
                                    n_phase = '0;
                                    n_rem   = rem_dec;
                                    if (rem_dec == '0) begin
                                        n_top    = '0;
                                        n_half   = '0;
                                        n_active = 1'b0;
                                    end
                                end else begin
                                    n_phase = r_phase + 1'b1;
                                end
                            end
                        end
                        ctbg_pkg::REQ_START: begin
                            if (dur_in == '0) begin
                                load_out = 1'b1;
                            end else begin
                                div_start = 1'b1;
                                n_state   = ctbg_pkg::S_DIVT;
                            end
                        end
                        ctbg_pkg::REQ_STOP: begin
                            load_out = 1'b1;
                            n_phase  = '0;
                            n_top    = '0;
                            n_half   = '0;
                            n_rem    = '0;
                            n_active = 1'b0;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ctbg_pkg::S_DIVT: begin
                if (div_done) begin
                    n_state = ctbg_pkg::S_MUL;
                end
            end
            ctbg_pkg::S_MUL: begin
                div_start = 1'b1;
                n_state   = ctbg_pkg::S_DIVP;
            end
            ctbg_pkg::S_DIVP: begin
                if (div_done) begin
                    n_top    = r_ticks - 1'b1;
                    n_half   = r_ticks >> 1;
                    n_phase  = '0;
                    n_rem    = periods_c;
                    n_active = 1'b1;
                    n_acc    = 1'b1;
                    load_out = 1'b1;
                    n_state  = ctbg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ctbg_pkg::S_IDLE;
            end
        endcase
    end

    assign drive_a = n_active && (n_phase < n_half);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz  <= ctbg_pkg::CLOCK_DEFAULT;
            r_state     <= ctbg_pkg::S_IDLE;
            r_phase     <= '0;
            r_top       <= '0;
            r_half      <= '0;
            r_rem       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_clock_hz <= i_cfg_data;
            end
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_top    <= n_top;
            r_half   <= n_half;
            r_rem    <= n_rem;
            r_active <= n_active;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_freq <= freq_cl;
            r_dur  <= dur_in;
        end
        if (r_state == ctbg_pkg::S_DIVT && div_done) begin
            r_ticks <= ticks_c;
            r_prod  <= ({16'b0, r_dur} * {32'b0, r_freq}) + ctbg_pkg::ROUND_HALF;
        end
        if (load_out) begin
            r_out_data <= {n_acc, n_active, n_active && !drive_a, drive_a};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_data};

    // a running burst has a period of at least two ticks
    a_top_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_top != '0))
        else $error("active burst with empty period");

    // phase counter stays inside the period
    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_phase <= r_top))
        else $error("phase counter beyond period end");

    // a running burst always has periods left, an idle one none
    a_rem_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == (r_rem != '0))
        else $error("period count disagrees with burst state");

    // a result word is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !load_out)
        else $error("stalled result word overwritten");

endmodule
